// ===== hw/rtl/cmjd_pkg.sv =====
// Package for the civil date / Modified Julian Date converter.
// Holds the request and result transfer types, op codes, constants and the month table.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package cmjd_pkg;

    // Op codes carried in the request.
    localparam logic OP_TO_MJD   = 1'b0;
    localparam logic OP_TO_CIVIL = 1'b1;

    // Calendar constants.
    localparam logic [11:0] YEAR_MIN       = 12'd1900;
    localparam logic [10:0] DAYS_PER_4YR   = 11'd1461;
    localparam logic [20:0] MJD_OFFSET     = 21'd679019;
    localparam logic [16:0] MJD_MIN_VALID  = 17'd15020;
    localparam logic [20:0] MJD_MAX        = 21'd131071;
    localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
    localparam logic [21:0] JD_IB_BASE     = 22'd2401538;
    localparam logic [6:0]  IB_SCALE       = 7'd100;
    localparam logic [27:0] IB_BIAS        = 28'd12210;
    localparam logic [12:0] YEAR_BASE      = 13'd4715;

    // Reciprocal dividers: divisor and reciprocal shift for each use.
    localparam int YEAR_DIVISOR = 36525;
    localparam int YEAR_SHIFT   = 41;
    localparam int HOUR_DIVISOR = 3600;
    localparam int HOUR_SHIFT   = 24;
    localparam int MIN_DIVISOR  = 60;
    localparam int MIN_SHIFT    = 18;

    // One request transfer.
    typedef struct packed {
        logic        op;
        logic [11:0] civil_year;
        logic [3:0]  civil_month;
        logic [4:0]  civil_day;
        logic [4:0]  civil_hour;
        logic [5:0]  civil_minute;
        logic [5:0]  civil_second;
        logic [16:0] mjd_in;
        logic [16:0] day_seconds_in;
    } cmjd_req_t;

    // One result transfer.
    typedef struct packed {
        logic [16:0] mjd_out;
        logic [16:0] day_seconds_out;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        range_error;
    } cmjd_res_t;

    // Days spanned by k months of 30.6001 days, rounded down.
    function automatic logic [8:0] month_span(input logic [4:0] k);
        logic [8:0] span;
        case (k)
            5'd1:    span = 9'd30;
            5'd2:    span = 9'd61;
            5'd3:    span = 9'd91;
            5'd4:    span = 9'd122;
            5'd5:    span = 9'd153;
            5'd6:    span = 9'd183;
            5'd7:    span = 9'd214;
            5'd8:    span = 9'd244;
            5'd9:    span = 9'd275;
            5'd10:   span = 9'd306;
            5'd11:   span = 9'd336;
            5'd12:   span = 9'd367;
            5'd13:   span = 9'd397;
            5'd14:   span = 9'd428;
            5'd15:   span = 9'd459;
            5'd16:   span = 9'd489;
            default: span = 9'd0;
        endcase
        return span;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cmjd_const_div.sv =====
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Registers the estimate, then registers the corrected quotient and remainder; self-contained.
`timescale 1ns / 1ps
`default_nettype none

module cmjd_const_div #(
    parameter int X_W     = 17,
    parameter int Q_W     = 5,
    parameter int DIVISOR = 3600,
    parameter int SHIFT   = 24,
    parameter int REM_W   = $clog2(DIVISOR)
) (
    input  wire logic             clk,
    input  wire logic [X_W-1:0]   dividend,
    output logic      [Q_W-1:0]   quotient,
    output logic      [REM_W-1:0] remainder
);

    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'(DIVISOR);
    localparam int R_W = $clog2(RECIP + 64'd1);
    localparam int P_W = X_W + R_W;
    localparam logic [X_W-1:0] DIV_X = X_W'(DIVISOR);

    logic [X_W-1:0]   x_reg;
    logic [Q_W-1:0]   qest_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [REM_W-1:0] rem_reg;
    logic [P_W-1:0]   prod;
    logic [P_W-1:0]   prod_sh;
    logic [X_W-1:0]   qd;
    logic [X_W-1:0]   rdiff;
    logic [Q_W-1:0]   quot_next;
    logic [REM_W-1:0] rem_next;

    // Estimate: low by at most one since the dividend stays below 2^SHIFT.
    assign prod    = P_W'(dividend) * P_W'(RECIP[R_W-1:0]);
    assign prod_sh = prod >> SHIFT;

    always_ff @(posedge clk)
    begin
        x_reg    <= dividend;
        qest_reg <= prod_sh[Q_W-1:0];
    end

    // Correction: the partial remainder is below twice the divisor.
    assign qd    = X_W'(qest_reg) * DIV_X;
    assign rdiff = x_reg - qd;

    always_comb
    begin
        if (rdiff >= DIV_X)
        begin
            quot_next = qest_reg + Q_W'(1);
            rem_next  = REM_W'(rdiff - DIV_X);
        end
        else
        begin
            quot_next = qest_reg;
            rem_next  = REM_W'(rdiff);
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/civil_mjd_date_converter_top.sv =====
// Top level of the civil date / Modified Julian Date converter pipeline.
// Depends on cmjd_pkg and cmjd_const_div.
//
// Usage:
//   A request transfer is taken at a rising edge with start high and busy low.
//   op selects civil-to-MJD or MJD-to-civil; fields of the other direction are
//   ignored and read back as zero in the result.
//   Each request gives one result, shown on result for exactly one cycle with
//   done high. Results come back in request order.
//   A request passes the stage 1 to 5 registers and the result register before done.
//   Throughput is one request per cycle: six register stages, the longest path
//   being the 28 by 26 bit reciprocal multiply of the year divider.
//   The receiver cannot stall; no back-pressure exists, so busy stays low in
//   normal operation.
//   Reset clears all valid bits and holds busy high; busy drops in the cycle after
//   reset is released. Items in flight at reset are dropped.
//   The range flag marks a year below 1900, an MJD that does not fit 17 bits,
//   or an input MJD below 15020.
`timescale 1ns / 1ps
`default_nettype none

module civil_mjd_date_converter_top
    import cmjd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire cmjd_req_t request,
    output logic           done,
    output cmjd_res_t      result
);

    // Bounds on days from the start of the March-based year.
    localparam logic [21:0] DIFF_MIN = 22'd122;
    localparam logic [21:0] DIFF_MAX = 22'd489;

    // Control registers.
    logic busy_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;
    logic v1_next;

    // Stage 1 payload.
    logic        s1_op_reg;
    logic [22:0] s1_yprod_reg;
    logic [8:0]  s1_span_reg;
    logic [4:0]  s1_day_reg;
    logic [16:0] s1_dsec0_reg;
    logic        s1_ylow_reg;
    logic [21:0] s1_ib_reg;
    logic [27:0] s1_num_reg;
    logic [16:0] s1_dsec1_reg;
    logic        s1_err1_reg;

    // Stage 2 to 5 payload.
    logic        s2_op_reg, s3_op_reg, s4_op_reg, s5_op_reg;
    logic        s2_err_reg, s3_err_reg, s4_err_reg, s5_err_reg;
    logic [16:0] s2_mjd0_reg, s3_mjd0_reg, s4_mjd0_reg, s5_mjd0_reg;
    logic [16:0] s2_dsec0_reg, s3_dsec0_reg, s4_dsec0_reg, s5_dsec0_reg;
    logic [21:0] s2_ib_reg, s3_ib_reg, s4_ib_reg;
    logic [12:0] s4_c_reg, s5_c_reg;
    logic [4:0]  s4_hour_reg, s5_hour_reg;
    logic [23:0] s4_cprod_reg;
    logic [8:0]  s5_diff_reg;
    logic [3:0]  s5_e_reg;
    cmjd_res_t   res_reg;

    // Stage 1 next values.
    logic [11:0] y_adj;
    logic [3:0]  m_adj;
    logic [22:0] s1_yprod_next;
    logic [8:0]  s1_span_next;
    logic [16:0] s1_dsec0_next;
    logic        s1_ylow_next;
    logic [16:0] s1_dsec1_next;
    logic [17:0] mjd1;
    logic [21:0] s1_ib_next;
    logic [27:0] s1_num_next;
    logic        s1_err1_next;

    // Stage 2 next values.
    logic [20:0] sum0;
    logic [20:0] mjd0_full;
    logic        s2_err_next;
    logic [16:0] s2_mjd0_next;

    // Divider outputs.
    logic [12:0] c_div;
    logic [15:0] year_rem;
    logic [4:0]  hour_div;
    logic [11:0] rest_div;
    logic [5:0]  minute_div;
    logic [5:0]  second_div;

    // Stage 4 and 5 next values.
    logic [23:0] s4_cprod_next;
    logic [21:0] diff_full;
    logic [3:0]  s5_e_next;
    logic [8:0]  it1;
    logic [8:0]  dd;
    logic [3:0]  mo;
    logic [12:0] yr_full;
    cmjd_res_t   res_next;

    // Handshake: a transfer is taken whenever start is high and busy is low.
    assign v1_next = start & ~busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v1_reg   <= v1_next;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // Stage 1, civil side: fold January and February into the year before.
    always_comb
    begin
        y_adj = request.civil_year;
        m_adj = request.civil_month;
        if (request.civil_month <= 4'd2)
        begin
            y_adj = request.civil_year - 12'd1;
            m_adj = request.civil_month + 4'd12;
        end
        s1_yprod_next = 23'(y_adj) * 23'(DAYS_PER_4YR);
        s1_span_next  = month_span(5'(m_adj) + 5'd1);
        s1_dsec0_next = 17'(17'(request.civil_hour) * 17'd3600)
                      + 17'(17'(request.civil_minute) * 17'd60)
                      + 17'(request.civil_second);
        s1_ylow_next  = (request.civil_year < YEAR_MIN);
    end

    // Stage 1, MJD side: carry a full day of seconds, then form the scaled day.
    always_comb
    begin
        s1_err1_next  = (request.mjd_in < MJD_MIN_VALID);
        s1_dsec1_next = request.day_seconds_in;
        mjd1          = 18'(request.mjd_in);
        if (request.day_seconds_in >= SEC_PER_DAY)
        begin
            s1_dsec1_next = request.day_seconds_in - SEC_PER_DAY;
            mjd1          = 18'(request.mjd_in) + 18'd1;
        end
        s1_ib_next  = 22'(mjd1) + JD_IB_BASE;
        s1_num_next = 28'(s1_ib_next) * 28'(IB_SCALE) - IB_BIAS;
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= request.op;
        s1_yprod_reg <= s1_yprod_next;
        s1_span_reg  <= s1_span_next;
        s1_day_reg   <= request.civil_day;
        s1_dsec0_reg <= s1_dsec0_next;
        s1_ylow_reg  <= s1_ylow_next;
        s1_ib_reg    <= s1_ib_next;
        s1_num_reg   <= s1_num_next;
        s1_dsec1_reg <= s1_dsec1_next;
        s1_err1_reg  <= s1_err1_next;
    end

    // Stage 2: finish the civil-to-MJD sum and its range checks.
    always_comb
    begin
        sum0         = 21'(s1_yprod_reg >> 2) + 21'(s1_span_reg) + 21'(s1_day_reg);
        mjd0_full    = sum0 - MJD_OFFSET;
        s2_mjd0_next = 17'd0;
        if (s1_ylow_reg || (sum0 < MJD_OFFSET) || (mjd0_full > MJD_MAX))
        begin
            s2_err_next = 1'b1;
        end
        else
        begin
            s2_err_next  = 1'b0;
            s2_mjd0_next = mjd0_full[16:0];
        end
        if (s1_op_reg == OP_TO_CIVIL)
        begin
            s2_err_next = s1_err1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_err_reg   <= s2_err_next;
        s2_mjd0_reg  <= s2_mjd0_next;
        s2_dsec0_reg <= s1_dsec0_reg;
        s2_ib_reg    <= s1_ib_reg;
    end

    // Stages 2 and 3, MJD side: years since the epoch and hours of the day.
    cmjd_const_div #(
        .X_W     (28),
        .Q_W     (13),
        .DIVISOR (YEAR_DIVISOR),
        .SHIFT   (YEAR_SHIFT)
    ) u_year_div (
        .clk       (clk),
        .dividend  (s1_num_reg),
        .quotient  (c_div),
        .remainder (year_rem)
    );

    cmjd_const_div #(
        .X_W     (17),
        .Q_W     (5),
        .DIVISOR (HOUR_DIVISOR),
        .SHIFT   (HOUR_SHIFT),
        .REM_W   (12)
    ) u_hour_div (
        .clk       (clk),
        .dividend  (s1_dsec1_reg),
        .quotient  (hour_div),
        .remainder (rest_div)
    );

    always_ff @(posedge clk)
    begin
        s3_op_reg    <= s2_op_reg;
        s3_err_reg   <= s2_err_reg;
        s3_mjd0_reg  <= s2_mjd0_reg;
        s3_dsec0_reg <= s2_dsec0_reg;
        s3_ib_reg    <= s2_ib_reg;
    end

    // Stage 3: whole days in the elapsed Julian years.
    assign s4_cprod_next = 24'(c_div) * 24'(DAYS_PER_4YR);

    always_ff @(posedge clk)
    begin
        s4_op_reg    <= s3_op_reg;
        s4_err_reg   <= s3_err_reg;
        s4_mjd0_reg  <= s3_mjd0_reg;
        s4_dsec0_reg <= s3_dsec0_reg;
        s4_ib_reg    <= s3_ib_reg;
        s4_c_reg     <= c_div;
        s4_hour_reg  <= hour_div;
        s4_cprod_reg <= s4_cprod_next;
    end

    // Stages 4 and 5: minutes and seconds of the remaining hour.
    cmjd_const_div #(
        .X_W     (12),
        .Q_W     (6),
        .DIVISOR (MIN_DIVISOR),
        .SHIFT   (MIN_SHIFT)
    ) u_min_div (
        .clk       (clk),
        .dividend  (rest_div),
        .quotient  (minute_div),
        .remainder (second_div)
    );

    // Stage 4: day within the year and the month count from the month table.
    assign diff_full = s4_ib_reg - 22'(s4_cprod_reg >> 2);

    always_comb
    begin
        s5_e_next = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (diff_full[8:0] > month_span(5'(k)))
            begin
                s5_e_next = 4'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s5_op_reg    <= s4_op_reg;
        s5_err_reg   <= s4_err_reg;
        s5_mjd0_reg  <= s4_mjd0_reg;
        s5_dsec0_reg <= s4_dsec0_reg;
        s5_c_reg     <= s4_c_reg;
        s5_hour_reg  <= s4_hour_reg;
        s5_diff_reg  <= diff_full[8:0];
        s5_e_reg     <= s5_e_next;
    end

    // Stage 5: day, month and year, then the result for either direction.
    always_comb
    begin
        it1 = month_span(5'(s5_e_reg));
        dd  = s5_diff_reg - it1;
        if (s5_e_reg >= 4'd14)
        begin
            mo = s5_e_reg - 4'd13;
        end
        else
        begin
            mo = s5_e_reg - 4'd1;
        end
        yr_full = s5_c_reg - YEAR_BASE - 13'(mo >= 4'd3);

        res_next             = '0;
        res_next.range_error = s5_err_reg;
        if (s5_op_reg == OP_TO_MJD)
        begin
            res_next.mjd_out         = s5_mjd0_reg;
            res_next.day_seconds_out = s5_dsec0_reg;
        end
        else
        begin
            res_next.out_year   = yr_full[11:0];
            res_next.out_month  = mo;
            res_next.out_day    = dd[4:0];
            res_next.out_hour   = s5_hour_reg;
            res_next.out_minute = minute_div;
            res_next.out_second = second_div;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

    // Every accepted transfer comes out as a result with done high.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted request did not give a result after six cycles");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a matching request");

    // The year divider must leave the day within the March-based year.
    a_year_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && s4_op_reg == OP_TO_CIVIL) |->
            (diff_full >= DIFF_MIN && diff_full <= DIFF_MAX))
        else $error("year quotient off by one");

    // The year divider remainder stays below its divisor.
    a_year_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (year_rem < 16'(YEAR_DIVISOR)))
        else $error("year remainder out of range");

    // Time-of-day dividers must give fields in range.
    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_hour < 5'd24 && result.out_minute < 6'd60
                  && result.out_second < 6'd60))
        else $error("time of day field out of range");

    a_civil_day: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_month != 4'd0) |-> result.out_day != 5'd0)
        else $error("civil result with a zero day");

endmodule

`default_nettype wire
